// File: src/ihr_pkg.sv
// ------------------------------------------------------------------------------------------
// IPv6 header rewrite package
// Shared widths, codes, word positions, types and checksum helpers.
// ------------------------------------------------------------------------------------------
package ihr_pkg;

	localparam int HEADER_WORDS_DEFAULT = 64;
	localparam int IDX_W = 6;
	localparam int WORD_W = 16;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef logic [1:0] action_t;
	localparam action_t ACT_LOAD    = 2'd0;
	localparam action_t ACT_REWRITE = 2'd1;
	localparam action_t ACT_READ    = 2'd2;

	typedef logic [1:0] bsel_t;
	localparam bsel_t SEL_WORD = 2'd0;
	localparam bsel_t SEL_HIGH = 2'd1;
	localparam bsel_t SEL_LOW  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NOT_V6,
		ST_NXT,
		ST_RANGE
	} status_t;

	localparam idx_t IDX_VFC        = 6'd7;
	localparam idx_t IDX_PLEN       = 6'd9;
	localparam idx_t IDX_NXT        = 6'd10;
	localparam idx_t IDX_ADDR_FIRST = 6'd11;
	localparam idx_t IDX_ADDR_LAST  = 6'd26;
	localparam idx_t IDX_TRANSPORT  = 6'd27;
	localparam idx_t IDX_CK_ICMP6   = 6'd28;
	localparam idx_t IDX_CK_UDP     = 6'd30;
	localparam idx_t IDX_CK_TCP     = 6'd35;
	localparam idx_t IDX_NONE       = 6'd0;

	localparam logic [7:0] PROTO_TCP   = 8'd6;
	localparam logic [7:0] PROTO_UDP   = 8'd17;
	localparam logic [7:0] PROTO_ICMP6 = 8'd58;
	localparam logic [3:0] VERSION_V6  = 4'd6;

	localparam word_t WORD_MASK = 16'hffff;

	// Words that the block keeps in flip-flops, as they are read at fixed places.
	typedef struct packed {
		word_t vfc;
		word_t nxt;
		word_t ck_icmp6;
		word_t ck_udp;
		word_t ck_tcp;
	} spec_words_t;

	typedef struct packed {
		logic  we;
		idx_t  idx;
		word_t data;
	} word_wr_t;

	function automatic word_t merge_word(word_t old_w, word_t val, bsel_t sel);
		word_t mask;
		case (sel)
			SEL_HIGH: mask = 16'hff00;
			SEL_LOW:  mask = 16'h00ff;
			default:  mask = WORD_MASK;
		endcase
		return (old_w & ~mask) | (val & mask);
	endfunction

	// HC' = ~(~HC + ~old + new), end-around carries folded twice.
	function automatic word_t csum_patch(word_t hc, word_t old_w, word_t new_w);
		logic [WORD_W+1:0] s0;
		logic [WORD_W:0]   s1;
		logic [WORD_W:0]   s2;
		s0 = {2'b00, ~hc} + {2'b00, ~old_w} + {2'b00, new_w};
		s1 = {1'b0, s0[WORD_W-1:0]} + {15'd0, s0[WORD_W+1:WORD_W]};
		s2 = {1'b0, s1[WORD_W-1:0]} + {16'd0, s1[WORD_W]};
		return ~s2[WORD_W-1:0];
	endfunction

	function automatic idx_t cksum_pos(word_t nxt_word);
		case (nxt_word[15:8])
			PROTO_UDP:   return IDX_CK_UDP;
			PROTO_TCP:   return IDX_CK_TCP;
			PROTO_ICMP6: return IDX_CK_ICMP6;
			default:     return IDX_NONE;
		endcase
	endfunction

	function automatic word_t spec_word_at(spec_words_t sw, idx_t idx);
		case (idx)
			IDX_VFC:      return sw.vfc;
			IDX_NXT:      return sw.nxt;
			IDX_CK_ICMP6: return sw.ck_icmp6;
			IDX_CK_UDP:   return sw.ck_udp;
			IDX_CK_TCP:   return sw.ck_tcp;
			default:      return '0;
		endcase
	endfunction

endpackage

// File: src/ipv6_header_rewrite_incremental_checksum_unit.sv
// A request is held in the stage registers; its result is registered at the output when the stage advances.
// Throughput: one request per cycle while the output is not stalled, paced by the single
// registered read port of the header word store, which is read on the accepting edge.
// Reset clears the valid flags and the store's forwarding flag only; header words hold
// no value until written.
// ------------------------------------------------------------------------------------------
// IPv6 header rewrite with incremental checksum
// Stores header words, serves loads, reads and rewrites, and keeps the transport
// checksum up to date by one's-complement patching.
// ------------------------------------------------------------------------------------------
module ipv6_header_rewrite_incremental_checksum_unit
	import ihr_pkg::*;
#(
	parameter int HEADER_WORDS = HEADER_WORDS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // word_index[5:0], new_value[21:6], zero fill
	input  logic [3:0]  s_axis_tuser,  // action[1:0], byte_select[3:2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // read_word[15:0], checksum_now[31:16]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	logic        valid_s1;
	action_t     action_s1;
	idx_t        idx_s1;
	word_t       value_s1;
	bsel_t       sel_s1;
	logic        accept;
	logic        advance;
	logic        out_valid_q;
	word_t       read_word_q;
	word_t       checksum_q;
	status_t     status_q;
	spec_words_t spec_q;
	spec_words_t spec_next;
	word_wr_t    upd_wr;
	word_wr_t    mem_wr;
	word_t       mem_word;
	word_t       read_word;
	word_t       checksum_now;
	status_t     status;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= s_axis_tdata[5:0];
			value_s1 <= s_axis_tdata[21:6];
			action_s1 <= s_axis_tuser[1:0];
			sel_s1 <= s_axis_tuser[3:2];
		end
	end

	// The store is written only when the item in the stage completes.
	assign mem_wr.we = upd_wr.we && advance;
	assign mem_wr.idx = upd_wr.idx;
	assign mem_wr.data = upd_wr.data;

	ihr_word_store #(
		.HEADER_WORDS(HEADER_WORDS)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_idx(s_axis_tdata[5:0]),
		.wr(mem_wr),
		.rd_word(mem_word)
	);

	ihr_update #(
		.HEADER_WORDS(HEADER_WORDS)
	) u_update (
		.action(action_s1),
		.word_index(idx_s1),
		.new_value(value_s1),
		.byte_select(sel_s1),
		.mem_word(mem_word),
		.spec(spec_q),
		.spec_next(spec_next),
		.wr(upd_wr),
		.read_word(read_word),
		.checksum_now(checksum_now),
		.status(status)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			spec_q <= spec_next;
			read_word_q <= read_word;
			checksum_q <= checksum_now;
			status_q <= status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {checksum_q, read_word_q};
	assign m_axis_tuser = status_q;

endmodule

// File: src/ihr_word_store.sv
// ------------------------------------------------------------------------------------------
// Header word store
// Single-port-read memory of header words with a registered read and write forwarding.
// ------------------------------------------------------------------------------------------
module ihr_word_store
	import ihr_pkg::*;
#(
	parameter int HEADER_WORDS = HEADER_WORDS_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rd_en,
	input  idx_t     rd_idx,
	input  word_wr_t wr,
	output word_t    rd_word
);

	localparam int MEM_DEPTH = (HEADER_WORDS < (1 << IDX_W)) ? HEADER_WORDS : (1 << IDX_W);

	word_t mem [MEM_DEPTH];
	word_t rd_q;
	word_t fwd_data_q;
	logic  fwd_q;
	logic  rd_in_range;

	assign rd_in_range = 32'(rd_idx) < MEM_DEPTH;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.idx] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en && rd_in_range) begin
			rd_q <= mem[rd_idx];
		end
		if (rd_en) begin
			fwd_data_q <= wr.data;
		end
	end

	// A write landing on the edge that reads the same word is passed on directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr.we && (wr.idx == rd_idx);
		end
	end

	assign rd_word = fwd_q ? fwd_data_q : rd_q;

endmodule

// File: src/ihr_update.sv
// ------------------------------------------------------------------------------------------
// Header rewrite update logic
// Merges the new word, checks version and next header, and patches the checksum.
// ------------------------------------------------------------------------------------------
module ihr_update
	import ihr_pkg::*;
#(
	parameter int HEADER_WORDS = HEADER_WORDS_DEFAULT
) (
	input  action_t     action,
	input  idx_t        word_index,
	input  word_t       new_value,
	input  bsel_t       byte_select,
	input  word_t       mem_word,
	input  spec_words_t spec,
	output spec_words_t spec_next,
	output word_wr_t    wr,
	output word_t       read_word,
	output word_t       checksum_now,
	output status_t     status
);

	logic  in_range;
	logic  is_special;
	logic  v6_now;
	logic  v6_next;
	logic  covered;
	logic  do_write;
	logic  patch_en;
	idx_t  pos_now;
	idx_t  pos_next;
	word_t old_w;
	word_t new_w;
	word_t ck_w;
	word_t patched;

	assign in_range = 32'(word_index) < HEADER_WORDS;
	assign is_special = (word_index == IDX_VFC) || (word_index == IDX_NXT)
		|| (word_index == IDX_CK_ICMP6) || (word_index == IDX_CK_UDP)
		|| (word_index == IDX_CK_TCP);
	assign old_w = is_special ? spec_word_at(spec, word_index) : mem_word;
	assign new_w = merge_word(old_w, new_value, byte_select);

	assign v6_now = spec.vfc[15:12] == VERSION_V6;
	assign pos_now = cksum_pos(spec.nxt);
	assign ck_w = spec_word_at(spec, pos_now);
	assign patched = csum_patch(ck_w, old_w, new_w);

	assign covered = (word_index == IDX_PLEN)
		|| ((word_index >= IDX_ADDR_FIRST) && (word_index <= IDX_ADDR_LAST))
		|| (word_index >= IDX_TRANSPORT);

	always_comb begin
		status = ST_OK;
		do_write = 1'b0;
		patch_en = 1'b0;
		if (!in_range) begin
			status = ST_RANGE;
		end else if (action == ACT_LOAD) begin
			do_write = 1'b1;
		end else if (action == ACT_REWRITE) begin
			if (!v6_now) begin
				status = ST_NOT_V6;
			end else if (pos_now == IDX_NONE) begin
				status = ST_NXT;
			end else begin
				do_write = 1'b1;
				patch_en = covered && (word_index != pos_now);
			end
		end
	end

	// The patched checksum never lands on the word being rewritten, so the order is free.
	always_comb begin
		spec_next = spec;
		if (patch_en) begin
			case (pos_now)
				IDX_CK_ICMP6: spec_next.ck_icmp6 = patched;
				IDX_CK_UDP:   spec_next.ck_udp = patched;
				IDX_CK_TCP:   spec_next.ck_tcp = patched;
				default:      spec_next = spec;
			endcase
		end
		if (do_write) begin
			case (word_index)
				IDX_VFC:      spec_next.vfc = new_w;
				IDX_NXT:      spec_next.nxt = new_w;
				IDX_CK_ICMP6: spec_next.ck_icmp6 = new_w;
				IDX_CK_UDP:   spec_next.ck_udp = new_w;
				IDX_CK_TCP:   spec_next.ck_tcp = new_w;
				default:      ;
			endcase
		end
	end

	assign wr.we = do_write;
	assign wr.idx = word_index;
	assign wr.data = new_w;

	assign read_word = !in_range ? '0 : (do_write ? new_w : old_w);

	assign v6_next = spec_next.vfc[15:12] == VERSION_V6;
	assign pos_next = cksum_pos(spec_next.nxt);
	assign checksum_now = (v6_next && (pos_next != IDX_NONE))
		? spec_word_at(spec_next, pos_next) : '0;

endmodule
